### rtl/bncp_pkg.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: shared package
// Slot layout, operation codes, register map and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bncp_pkg;

    localparam int ID_W    = 32;
    localparam int MERIT_W = 32;
    localparam int CAP_W   = 5;   // pool_capacity register width
    localparam int COUNT_W = 5;   // pool_count result width
    localparam int REG_W   = 32;  // configuration data width
    localparam int PADDR_W = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Register indexes (byte address / 4).
    localparam logic [REG_IDX_W-1:0] REG_POOL_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes of an input word.
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Kinds of a result word.
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MERIT_W-1:0] merit;
    } t_slot;

    localparam int SLOT_W = ID_W + MERIT_W;

    typedef struct packed {
        logic capture;     // latch the input word, clear per-item flags
        logic append;      // write the new candidate at the fill position
        logic head_rd;     // read slot 0
        logic replace;     // overwrite slot 0 with the new candidate
        logic scan_start;  // restart the slot scan at the base index
        logic scan_run;    // issue reads and compare returned slots
        logic drain_mode;  // scan compares for the sort, not the minimum
        logic swap_a;      // write the old head into the minimum's slot
        logic swap_b;      // write the minimum into slot 0
        logic base_inc;    // advance the sort pass
        logic emit_offer;  // load an offer reply into the output register
        logic emit_entry;  // load a drained entry, write the pass result back
        logic emit_empty;  // load the reply for an empty drain
    } t_cmd;

    typedef struct packed {
        logic has_room;
        logic fill_zero;
        logic new_gt_head;
        logic scan_done;
        logic base_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/bncp_ram.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bncp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bncp_dp.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: datapath
// Slot memory, fill count, threshold, scan pipeline and output register.
// ----------------------------------------------------------------------------
module bncp_dp #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bncp_pkg::t_cmd                  i_cmd,
    output bncp_pkg::t_stat                 o_stat,
    input  logic [bncp_pkg::ID_W-1:0]       i_candidate_id,
    input  logic [bncp_pkg::MERIT_W-1:0]    i_merit,
    input  logic [bncp_pkg::CAP_W-1:0]      i_capacity,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic                            o_reply_kind,
    output logic                            o_accepted,
    output logic                            o_evicted_valid,
    output logic [bncp_pkg::ID_W-1:0]       o_evicted_id,
    output logic [bncp_pkg::COUNT_W-1:0]    o_pool_count,
    output logic [bncp_pkg::MERIT_W-1:0]    o_threshold,
    output logic                            o_entry_valid,
    output logic [bncp_pkg::ID_W-1:0]       o_entry_id,
    output logic [bncp_pkg::MERIT_W-1:0]    o_entry_merit,
    output logic                            o_last
);
    import bncp_pkg::*;

    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    t_slot               r_item,     n_item;
    t_slot               r_best,     n_best;
    t_slot               r_head,     n_head;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [CNT_W-1:0]    r_fill,     n_fill;
    logic [MERIT_W-1:0]  r_thr,      n_thr;
    logic [IDX_W-1:0]    r_base,     n_base;
    logic [CNT_W-1:0]    r_rd_idx,   n_rd_idx;
    logic                r_cmp_vld,  n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx,  n_cmp_idx;
    logic                r_acc,      n_acc;
    logic                r_ev,       n_ev;
    logic [ID_W-1:0]     r_evid,     n_evid;
    logic                r_upd,      n_upd;

    logic                r_out_valid,  n_out_valid;
    logic                r_out_kind,   n_out_kind;
    logic                r_out_acc,    n_out_acc;
    logic                r_out_ev,     n_out_ev;
    logic [ID_W-1:0]     r_out_evid,   n_out_evid;
    logic [COUNT_W-1:0]  r_out_count,  n_out_count;
    logic [MERIT_W-1:0]  r_out_thr,    n_out_thr;
    logic                r_out_evalid, n_out_evalid;
    logic [ID_W-1:0]     r_out_eid,    n_out_eid;
    logic [MERIT_W-1:0]  r_out_emerit, n_out_emerit;
    logic                r_out_last,   n_out_last;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    t_slot               ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [SLOT_W-1:0]   ram_rd_bits;
    t_slot               rd_slot;

    logic [CMP_W-1:0]    cap_eff;
    logic                issue;
    logic                base_last;
    logic                out_free;

    bncp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_bits)
    );

    assign rd_slot = ram_rd_bits;

    // A capacity of zero behaves as one; anything above the depth as the depth.
    always_comb begin
        cap_eff = CMP_W'(i_capacity);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end
        if (cap_eff > CMP_W'(POOL_DEPTH)) begin
            cap_eff = CMP_W'(POOL_DEPTH);
        end
    end

    assign issue     = i_cmd.scan_run && (r_rd_idx < r_fill);
    assign base_last = (CNT_W'(r_base) + CNT_W'(1)) == r_fill;
    assign out_free  = !r_out_valid || !i_stall;

    assign o_stat.has_room    = CMP_W'(r_fill) < cap_eff;
    assign o_stat.fill_zero   = (r_fill == '0);
    assign o_stat.new_gt_head = r_item.merit > rd_slot.merit;
    assign o_stat.scan_done   = r_cmp_vld && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_fill);
    assign o_stat.base_last   = base_last;
    assign o_stat.out_free    = out_free;

    always_comb begin
        n_item     = r_item;
        n_best     = r_best;
        n_head     = r_head;
        n_best_idx = r_best_idx;
        n_fill     = r_fill;
        n_thr      = r_thr;
        n_base     = r_base;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_acc      = r_acc;
        n_ev       = r_ev;
        n_evid     = r_evid;
        n_upd      = r_upd;

        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_acc    = r_out_acc;
        n_out_ev     = r_out_ev;
        n_out_evid   = r_out_evid;
        n_out_count  = r_out_count;
        n_out_thr    = r_out_thr;
        n_out_evalid = r_out_evalid;
        n_out_eid    = r_out_eid;
        n_out_emerit = r_out_emerit;
        n_out_last   = r_out_last;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = r_best;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        if (i_cmd.capture) begin
            n_item.id    = i_candidate_id;
            n_item.merit = i_merit;
            n_acc  = 1'b0;
            n_ev   = 1'b0;
            n_evid = '0;
            n_upd  = 1'b0;
            n_base = '0;
        end

        if (i_cmd.append) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_fill[IDX_W-1:0];
            ram_wr_data = r_item;
            n_fill      = r_fill + CNT_W'(1);
            n_acc       = 1'b1;
        end

        if (i_cmd.head_rd) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
        end

        if (i_cmd.replace) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = r_item;
            n_evid      = rd_slot.id;
            n_acc       = 1'b1;
            n_ev        = 1'b1;
            n_upd       = 1'b1;
        end

        if (i_cmd.scan_start) begin
            n_rd_idx = CNT_W'(r_base);
        end

        if (i_cmd.scan_run) begin
            // Read side: one slot per cycle; the read data returns in the next cycle.
            if (issue) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_rd_idx[IDX_W-1:0];
                n_rd_idx    = r_rd_idx + CNT_W'(1);
                n_cmp_idx   = r_rd_idx[IDX_W-1:0];
            end
            n_cmp_vld = issue;

            // Compare side.
            if (r_cmp_vld) begin
                if (r_cmp_idx == r_base) begin
                    n_best     = rd_slot;
                    n_best_idx = r_cmp_idx;
                    n_head     = rd_slot;
                end else if (i_cmd.drain_mode) begin
                    // Exchange sort: the held pivot trades places with any
                    // larger slot; the pivot's own slot is written at pass end.
                    if (rd_slot.merit > r_best.merit) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_cmp_idx;
                        ram_wr_data = r_best;
                        n_best      = rd_slot;
                    end
                end else if (rd_slot.merit < r_best.merit) begin
                    n_best     = rd_slot;
                    n_best_idx = r_cmp_idx;
                end
            end
        end

        if (i_cmd.swap_a) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_best_idx;
            ram_wr_data = r_head;
        end

        if (i_cmd.swap_b) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = r_best;
            if (r_upd) begin
                n_thr = r_best.merit;
            end
        end

        if (i_cmd.base_inc) begin
            n_base = r_base + IDX_W'(1);
        end

        if (i_cmd.emit_offer) begin
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_OFFER;
            n_out_acc    = r_acc;
            n_out_ev     = r_ev;
            n_out_evid   = r_evid;
            n_out_count  = COUNT_W'(r_fill);
            n_out_thr    = r_thr;
            n_out_evalid = 1'b0;
            n_out_eid    = '0;
            n_out_emerit = '0;
            n_out_last   = 1'b0;
        end

        if (i_cmd.emit_entry) begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = r_base;
            ram_wr_data  = r_best;
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_ENTRY;
            n_out_acc    = 1'b0;
            n_out_ev     = 1'b0;
            n_out_evid   = '0;
            n_out_count  = COUNT_W'(r_fill);
            n_out_thr    = r_thr;
            n_out_evalid = 1'b1;
            n_out_eid    = r_best.id;
            n_out_emerit = r_best.merit;
            n_out_last   = base_last;
        end

        if (i_cmd.emit_empty) begin
            n_out_valid  = 1'b1;
            n_out_kind   = KIND_ENTRY;
            n_out_acc    = 1'b0;
            n_out_ev     = 1'b0;
            n_out_evid   = '0;
            n_out_count  = COUNT_W'(r_fill);
            n_out_thr    = r_thr;
            n_out_evalid = 1'b0;
            n_out_eid    = '0;
            n_out_emerit = '0;
            n_out_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_thr       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_thr       <= n_thr;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
        r_item       <= n_item;
        r_best       <= n_best;
        r_head       <= n_head;
        r_best_idx   <= n_best_idx;
        r_base       <= n_base;
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_acc        <= n_acc;
        r_ev         <= n_ev;
        r_evid       <= n_evid;
        r_upd        <= n_upd;
        r_out_kind   <= n_out_kind;
        r_out_acc    <= n_out_acc;
        r_out_ev     <= n_out_ev;
        r_out_evid   <= n_out_evid;
        r_out_count  <= n_out_count;
        r_out_thr    <= n_out_thr;
        r_out_evalid <= n_out_evalid;
        r_out_eid    <= n_out_eid;
        r_out_emerit <= n_out_emerit;
        r_out_last   <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_reply_kind    = r_out_kind;
    assign o_accepted      = r_out_acc;
    assign o_evicted_valid = r_out_ev;
    assign o_evicted_id    = r_out_evid;
    assign o_pool_count    = r_out_count;
    assign o_threshold     = r_out_thr;
    assign o_entry_valid   = r_out_evalid;
    assign o_entry_id      = r_out_eid;
    assign o_entry_merit   = r_out_emerit;
    assign o_last          = r_out_last;

    // The fill count never passes the slot memory depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(POOL_DEPTH) >= r_fill)
        else $error("fill count above pool depth");

    // The fill count only holds or grows by one.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill == $past(r_fill)) ||
                           (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("fill count jumped");

    // At most one sequencer step drives the memory write port.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.append, i_cmd.replace, i_cmd.swap_a,
                  i_cmd.swap_b, i_cmd.emit_entry, i_cmd.scan_run}))
        else $error("write port conflict");

    // A slot under comparison always lies inside the filled part of the pool.
    a_cmp_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> CNT_W'(r_cmp_idx) < r_fill)
        else $error("scan compared a slot beyond the fill");

endmodule

### rtl/bncp_ctrl.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: controller
// Sequences offers (append or replace, minimum scan, swap to slot 0) and
// drains (one exchange-sort pass per emitted entry).
// ----------------------------------------------------------------------------
module bncp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_operation,
    output logic             o_stall,
    input  bncp_pkg::t_stat  i_stat,
    output bncp_pkg::t_cmd   o_cmd
);
    import bncp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OFFER  = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SWAP_A = 4'd4;
    localparam logic [3:0] S_SWAP_B = 4'd5;
    localparam logic [3:0] S_REPLY  = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_D_PASS = 4'd8;
    localparam logic [3:0] S_D_EMIT = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_drain, n_drain;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.drain_mode = r_drain;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_drain = (i_operation == OP_DRAIN);
                    n_state = (i_operation == OP_DRAIN) ? S_DRAIN : S_OFFER;
                end
            end
            S_OFFER: begin
                if (i_stat.has_room) begin
                    o_cmd.append     = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.new_gt_head) begin
                    o_cmd.replace    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = r_drain ? S_D_EMIT : S_SWAP_A;
                end
            end
            S_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_offer = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_stat.fill_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_D_PASS;
                end
            end
            S_D_PASS: begin
                o_cmd.scan_start = 1'b1;
                n_state = S_SCAN;
            end
            S_D_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_stat.base_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.base_inc = 1'b1;
                        n_state = S_D_PASS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

endmodule

### rtl/best_n_candidate_pool.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: top level
// Keeps the best scored candidates by merit, with replacement of the worst
// entry once full and a sorted, descending drain.
// ----------------------------------------------------------------------------
// Offer: taken in the idle state. On append or replacement the slot scan finds
//   the minimum and swaps it to slot 0 before the reply enters the output
//   register; a rejected offer replies after the head check. The scan reads
//   one slot a cycle. Drain: one exchange-sort pass per emitted entry.
// Reset is synchronous and active low: pool empty, threshold zero, capacity
//   16; slot memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module best_n_candidate_pool #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // Input channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_operation,
    input  logic [bncp_pkg::ID_W-1:0]          i_candidate_id,
    input  logic [bncp_pkg::MERIT_W-1:0]       i_merit,

    // Result channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_reply_kind,
    output logic                               o_accepted,
    output logic                               o_evicted_valid,
    output logic [bncp_pkg::ID_W-1:0]          o_evicted_id,
    output logic [bncp_pkg::COUNT_W-1:0]       o_pool_count,
    output logic [bncp_pkg::MERIT_W-1:0]       o_threshold,
    output logic                               o_entry_valid,
    output logic [bncp_pkg::ID_W-1:0]          o_entry_id,
    output logic [bncp_pkg::MERIT_W-1:0]       o_entry_merit,
    output logic                               o_last,

    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bncp_pkg::PADDR_W-1:0]       paddr,
    input  logic [bncp_pkg::REG_W-1:0]         pwdata,
    output logic [bncp_pkg::REG_W-1:0]         prdata,
    output logic                               pready
);
    import bncp_pkg::*;

    // The controller owns sequencing only; every slot, count and output
    // register sits in the datapath. Commands flow one way and status the
    // other, each as one struct.
    t_cmd  cmd;
    t_stat stat;

    // The capacity register. Software must write it only while the pool is idle (the
    // block does not enforce this), so the datapath reads it directly with no shadow copy.
    logic [CAP_W-1:0]     r_capacity, n_capacity;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_wr;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_capacity = r_capacity;
        if (reg_wr && (reg_idx == REG_POOL_CAPACITY)) begin
            n_capacity = pwdata[CAP_W-1:0];
        end
    end

    // Reads of an unmapped index return zero.
    assign prdata = (reg_idx == REG_POOL_CAPACITY) ? REG_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    bncp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the result in an output register, so the next word
    // is taken while an earlier result still waits downstream.
    bncp_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_candidate_id  (i_candidate_id),
        .i_merit         (i_merit),
        .i_capacity      (r_capacity),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_reply_kind    (o_reply_kind),
        .o_accepted      (o_accepted),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_pool_count    (o_pool_count),
        .o_threshold     (o_threshold),
        .o_entry_valid   (o_entry_valid),
        .o_entry_id      (o_entry_id),
        .o_entry_merit   (o_entry_merit),
        .o_last          (o_last)
    );

endmodule

### tb/bncp_pool_checker.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: result checker
// Watches the input, result and register channels. Keeps its own copy of
// the pool and compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module bncp_pool_checker #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           i_operation,
    input  logic [bncp_pkg::ID_W-1:0]      i_candidate_id,
    input  logic [bncp_pkg::MERIT_W-1:0]   i_merit,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic                           o_reply_kind,
    input  logic                           o_accepted,
    input  logic                           o_evicted_valid,
    input  logic [bncp_pkg::ID_W-1:0]      o_evicted_id,
    input  logic [bncp_pkg::COUNT_W-1:0]   o_pool_count,
    input  logic [bncp_pkg::MERIT_W-1:0]   o_threshold,
    input  logic                           o_entry_valid,
    input  logic [bncp_pkg::ID_W-1:0]      o_entry_id,
    input  logic [bncp_pkg::MERIT_W-1:0]   o_entry_merit,
    input  logic                           o_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bncp_pkg::PADDR_W-1:0]   paddr,
    input  logic [bncp_pkg::REG_W-1:0]     pwdata,
    input  logic [bncp_pkg::REG_W-1:0]     prdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bncp_pkg::*;

    typedef struct packed {
        logic               kind;
        logic               accepted;
        logic               ev_valid;
        logic [ID_W-1:0]    ev_id;
        logic [COUNT_W-1:0] count;
        logic [MERIT_W-1:0] thresh;
        logic               entry_valid;
        logic [ID_W-1:0]    entry_id;
        logic [MERIT_W-1:0] entry_merit;
        logic               last;
    } t_pool_reply;

    logic [ID_W-1:0]    pool_id    [POOL_DEPTH];
    logic [MERIT_W-1:0] pool_merit [POOL_DEPTH];
    int                 fill;
    logic [MERIT_W-1:0] thresh;
    logic [CAP_W-1:0]   cap_reg;
    t_pool_reply        due_replies [$];
    int                 errors;

    initial begin
        fail_count = 0;
        pending    = 0;
        errors     = 0;
        fill       = 0;
        thresh     = '0;
        cap_reg    = CAP_RESET;
    end

    function automatic int cap_limit();
        int c;
        c = int'(cap_reg);
        if (c == 0) c = 1;
        if (c > POOL_DEPTH) c = POOL_DEPTH;
        return c;
    endfunction

    function automatic void exchange(int a, int b);
        logic [ID_W-1:0]    tid;
        logic [MERIT_W-1:0] tmer;
        tid           = pool_id[a];
        tmer          = pool_merit[a];
        pool_id[a]    = pool_id[b];
        pool_merit[a] = pool_merit[b];
        pool_id[b]    = tid;
        pool_merit[b] = tmer;
    endfunction

    // The first slot holding the lowest merit moves to the head.
    function automatic logic [MERIT_W-1:0] hoist_minimum();
        int low;
        low = 0;
        if (fill == 0) return '0;
        for (int j = 1; j < fill && j < POOL_DEPTH; j++)
            if (pool_merit[j] < pool_merit[low]) low = j;
        if (low > 0) exchange(low, 0);
        return pool_merit[0];
    endfunction

    function automatic void apply_offer(logic [ID_W-1:0] id, logic [MERIT_W-1:0] mer);
        t_pool_reply r;
        r      = '0;
        r.kind = KIND_OFFER;
        if (fill < cap_limit()) begin
            pool_id[fill]    = id;
            pool_merit[fill] = mer;
            fill++;
            void'(hoist_minimum());
            r.accepted = 1'b1;
        end else if (fill > 0 && mer > pool_merit[0]) begin
            r.accepted    = 1'b1;
            r.ev_valid    = 1'b1;
            r.ev_id       = pool_id[0];
            pool_id[0]    = id;
            pool_merit[0] = mer;
            thresh        = hoist_minimum();
        end
        r.count  = COUNT_W'(fill);
        r.thresh = thresh;
        due_replies.push_back(r);
    endfunction

    function automatic void apply_drain();
        t_pool_reply        r;
        logic [MERIT_W-1:0] m;
        // Exchange sort, descending; ties keep the order this sort leaves.
        for (int a = 0; a + 1 < fill; a++) begin
            m = pool_merit[a];
            for (int b = a + 1; b < fill; b++) begin
                if (pool_merit[b] > m) begin
                    exchange(b, a);
                    m = pool_merit[a];
                end
            end
        end
        r        = '0;
        r.kind   = KIND_ENTRY;
        r.count  = COUNT_W'(fill);
        r.thresh = thresh;
        if (fill == 0) begin
            r.last = 1'b1;
            due_replies.push_back(r);
        end
        for (int k = 0; k < fill; k++) begin
            r.entry_valid = 1'b1;
            r.entry_id    = pool_id[k];
            r.entry_merit = pool_merit[k];
            r.last        = (k + 1 == fill);
            due_replies.push_back(r);
        end
    endfunction

    function automatic void show(string tag, t_pool_reply r);
        $display("  %s kind %0b acc %0b evict %0b/%h count %0d thr %h entry %0b %h %h last %0b",
                 tag, r.kind, r.accepted, r.ev_valid, r.ev_id, r.count, r.thresh,
                 r.entry_valid, r.entry_id, r.entry_merit, r.last);
    endfunction

    always @(posedge i_clk) begin : watch
        t_pool_reply got;
        t_pool_reply want;
        if (!i_rst_n) begin
            fill    = 0;
            thresh  = '0;
            cap_reg = CAP_RESET;
            due_replies.delete();
        end else begin
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_POOL_CAPACITY) begin
                if (pwrite) begin
                    cap_reg = pwdata[CAP_W-1:0];
                end else if (prdata !== REG_W'(cap_reg)) begin
                    if (errors < 10)
                        $display("mismatch at %0t: capacity read %h, expected %h",
                                 $time, prdata, REG_W'(cap_reg));
                    errors++;
                end
            end
            if (i_valid && !o_stall) begin
                if (i_operation == OP_OFFER) apply_offer(i_candidate_id, i_merit);
                else apply_drain();
            end
            if (o_valid && !i_stall) begin
                got = '{o_reply_kind, o_accepted, o_evicted_valid, o_evicted_id, o_pool_count,
                        o_threshold, o_entry_valid, o_entry_id, o_entry_merit, o_last};
                if (due_replies.size() == 0) begin
                    if (errors < 10) begin
                        $display("mismatch at %0t: result word with none expected", $time);
                        show("actual  ", got);
                    end
                    errors++;
                end else begin
                    want = due_replies.pop_front();
                    if (got !== want) begin
                        if (errors < 10) begin
                            $display("mismatch at %0t: result word differs", $time);
                            show("expected", want);
                            show("actual  ", got);
                        end
                        errors++;
                    end
                end
            end
        end
        pending    <= due_replies.size();
        fail_count <= errors;
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Best-N candidate pool: testbench top
// Drives offer and drain words and capacity settings into the pool, with
// random gaps on the input side and random stalls on the result side. The
// checker beside the block predicts every result word; this module only
// makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bncp_pkg::*;

    localparam int POOL_DEPTH     = 16;
    localparam int RANDOM_WORDS   = 460;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 64;

    // Register index with no register behind it; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = ~REG_POOL_CAPACITY;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_POOL_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};

    // How the merit of a random offer is drawn.
    typedef enum int {MERIT_WIDE, MERIT_LOW, MERIT_HIGH, MERIT_MIXED} t_merit_style;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 o_stall;
    logic                 i_operation     = OP_OFFER;
    logic [ID_W-1:0]      i_candidate_id  = '0;
    logic [MERIT_W-1:0]   i_merit         = '0;
    logic                 o_valid;
    logic                 i_stall         = 1'b0;
    logic                 o_reply_kind;
    logic                 o_accepted;
    logic                 o_evicted_valid;
    logic [ID_W-1:0]      o_evicted_id;
    logic [COUNT_W-1:0]   o_pool_count;
    logic [MERIT_W-1:0]   o_threshold;
    logic                 o_entry_valid;
    logic [ID_W-1:0]      o_entry_id;
    logic [MERIT_W-1:0]   o_entry_merit;
    logic                 o_last;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [PADDR_W-1:0]   paddr           = '0;
    logic [REG_W-1:0]     pwdata          = '0;
    logic [REG_W-1:0]     prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int idle_pct  = 14;
    int stall_pct = 14;
    int quiet_cycles = 0;

    best_n_candidate_pool #(.POOL_DEPTH(POOL_DEPTH)) dut (.*);

    bncp_pool_checker #(.POOL_DEPTH(POOL_DEPTH)) pool_watch (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The result side stalls at random; stall_pct drops to zero for the
    // quiet stretch so that back-to-back result words are seen as well.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: any cycle without a word moving on either channel counts.
    // The slowest legal gap is a full drain pass plus a few stalls, far
    // below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers or drains one word. Valid stays high from one word to the next
    // unless an idle gap is drawn, so it is never lowered and raised again
    // in the same time step. The word is taken at the first edge with the
    // stall low; the payload holds until then.
    task automatic send_word(input logic op, input logic [ID_W-1:0] id,
                             input logic [MERIT_W-1:0] mer);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_candidate_id <= id;
        i_merit        <= mer;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted result word has come
    // back. The pending count is registered in the checker, so it lags the
    // word that raised it.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One register transfer: setup cycle, then access cycle until pready.
    // The select is left high so that back-to-back transfers need only one
    // assignment per signal in a step; the caller releases the bus.
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [REG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Capacity changes happen only with the pool idle. Upper data bits are
    // random since only the low five bits are kept. The unmapped index gets
    // a random write each time, and the capacity is read back for the
    // checker to compare.
    task automatic reconfigure(input logic [CAP_W-1:0] cap);
        settle();
        reg_access(1'b1, ADDR_UNMAPPED, REG_W'($urandom));
        reg_access(1'b1, ADDR_CAPACITY, {(REG_W-CAP_W)'($urandom), cap});
        reg_access(1'b0, ADDR_CAPACITY, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Low and high styles crowd merits into sixteen values so that ties
    // with the pool minimum, and first-found minimum ordering, come often.
    function automatic logic [MERIT_W-1:0] pick_merit(t_merit_style style);
        t_merit_style s;
        s = style;
        if (s == MERIT_MIXED) s = t_merit_style'($urandom_range(2));
        case (s)
            MERIT_LOW:  return MERIT_W'($urandom_range(15));
            MERIT_HIGH: return {{(MERIT_W-4){1'b1}}, 4'($urandom_range(15))};
            default:    return MERIT_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int           sent;
        int           phase;
        int           words;
        logic [CAP_W-1:0] cap;
        t_merit_style style;
        logic [CAP_W-1:0] cap_plan [7];

        // The first random phases walk the capacity extremes: above the
        // depth, the depth itself, zero, just above the depth, and small
        // values that sit below the fill of the pool.
        cap_plan = '{5'd31, 5'd16, 5'd0, 5'd17, 5'd2, 5'd8, 5'd1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The pool can never be emptied after reset, so the
        // empty drain has to come first.
        send_word(OP_DRAIN, '1, '1);
        send_word(OP_OFFER, '0, '0);

        // Capacity zero acts as one: the pool is already full, so the next
        // offer replaces the head, an equal merit is refused, a lower one too.
        reconfigure(5'd0);
        send_word(OP_OFFER, '1, '1);
        send_word(OP_OFFER, 32'h1234_5678, '1);
        send_word(OP_OFFER, 32'h0000_0001, '0);
        send_word(OP_DRAIN, '0, '0);

        // Room for four appends; the threshold must not move while appending.
        reconfigure(5'd5);
        send_word(OP_OFFER, 32'hA5A5_A5A5, 32'h8000_0000);
        send_word(OP_OFFER, 32'h5A5A_5A5A, 32'h0000_0001);
        send_word(OP_OFFER, 32'h0F0F_0F0F, 32'h7FFF_FFFF);
        send_word(OP_OFFER, 32'hF0F0_F0F0, 32'h0100_0000);
        // A tie with the minimum is refused, a merit just above it replaces.
        send_word(OP_OFFER, 32'h0000_0011, 32'h0000_0001);
        send_word(OP_OFFER, 32'h0000_0022, 32'h0000_0002);
        send_word(OP_OFFER, 32'h0000_0033, 32'h0000_0000);
        send_word(OP_DRAIN, '0, '0);

        // Capacity lowered below the fill: the pool counts as full and keeps
        // all its entries; only the head can be replaced.
        reconfigure(5'd1);
        send_word(OP_OFFER, 32'h0000_0044, 32'h0000_0003);
        send_word(OP_OFFER, 32'h0000_0055, 32'hFFFF_FFFE);
        send_word(OP_DRAIN, '1, '0);

        // Random part: phases of a few dozen words, each with its own
        // capacity and merit style, separated by a full settle so that the
        // register write lands on an idle pool.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            cap   = (phase < 7) ? cap_plan[phase] : CAP_W'($urandom_range(31));
            style = t_merit_style'($urandom_range(3));
            reconfigure(cap);

            // One stretch runs without idles or stalls on either side.
            if (phase == 5) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = 14;
                stall_pct = 14;
            end

            words = $urandom_range(20, 45);
            if (words > RANDOM_WORDS - sent) words = RANDOM_WORDS - sent;
            repeat (words) begin
                if ($urandom_range(11) == 0)
                    send_word(OP_DRAIN, ID_W'($urandom), MERIT_W'($urandom));
                else
                    send_word(OP_OFFER, ID_W'($urandom), pick_merit(style));
                sent++;
            end
            phase++;
        end

        settle();
        stall_pct = 14;
        // Any result word beyond the predicted ones would show up here.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bncp_pkg.sv
rtl/bncp_ram.sv
rtl/bncp_dp.sv
rtl/bncp_ctrl.sv
rtl/best_n_candidate_pool.sv
tb/bncp_pool_checker.sv
tb/tb.sv
